// ===== sv/twsi_pkg.sv =====
// Shared constants and types for the table waveshaper.
// No dependencies; every other file of the block imports this package.
package twsi_pkg;

  localparam int SAMPLE_W       = 18;
  localparam int MAG_W          = SAMPLE_W - 1;
  localparam int OUT_W          = 20;
  localparam int OUT_MAX        = 524287;
  localparam int OUT_MIN        = -524288;

  localparam int SEG_COUNT_DEF  = 512;
  localparam int FRAC_BITS_DEF  = 15;

  localparam int QUEUE_DEPTH    = 4;
  localparam int BACK_STAGES    = 3;

  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // Register select is the word address bit of paddr
  localparam logic REG_SLOPE    = 1'b0;
  localparam logic REG_OFFSET   = 1'b1;

  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_SHAPE    = 1'b1;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Classification that travels with each queued word
  typedef struct packed {
    logic wr;
    logic neg;
    logic tail;
    logic blk;
  } twsi_ctl_t;

endpackage

// ===== sv/twsi_in_if.sv =====
// Input channel of the table waveshaper: valid/ready plus one input word.
// Depends on twsi_pkg.
interface twsi_in_if import twsi_pkg::*; #(
  parameter int IDX_W = $clog2(SEG_COUNT_DEF + 1)
) ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [SAMPLE_W-1:0] sample;
  logic        [IDX_W-1:0]    entry_index;
  logic signed [SAMPLE_W-1:0] entry_value;
  logic                       block_end;

  modport source (output valid, command, sample, entry_index, entry_value, block_end,
                  input ready);
  modport sink   (input valid, command, sample, entry_index, entry_value, block_end,
                  output ready);
endinterface

// ===== sv/twsi_out_if.sv =====
// Output channel of the table waveshaper: valid/ready plus one shaped word.
// Depends on twsi_pkg.
interface twsi_out_if import twsi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] shaped;
  logic                    block_end_out;

  modport source (output valid, shaped, block_end_out, input ready);
  modport sink   (input valid, shaped, block_end_out, output ready);
endinterface

// ===== sv/twsi_front.sv =====
// Front end: accepts input words, takes the sample magnitude and classifies
// each word (table write, table sample, tail sample). Depends on twsi_pkg, twsi_in_if.
module twsi_front import twsi_pkg::*; #(
  parameter int SEG_COUNT  = SEG_COUNT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int IDX_W      = $clog2(SEG_COUNT_DEF + 1)
) (
  twsi_in_if.sink             item,
  input  logic                q_ready,
  output logic                q_valid,
  output twsi_ctl_t           q_ctl,
  output logic [SAMPLE_W-1:0] q_val,
  output logic [IDX_W-1:0]    q_idx
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic signed [SAMPLE_W:0] neg_x;
  logic [MAG_W-1:0]         mag;
  logic                     is_wr;
  logic                     idx_ok;

  always_comb begin
    neg_x = -$signed({item.sample[SAMPLE_W-1], item.sample});
    if (!item.sample[SAMPLE_W-1]) begin
      mag = item.sample[MAG_W-1:0];
    end else if (neg_x[SAMPLE_W-1]) begin
      // most negative sample has no positive twin: saturate
      mag = MAG_MAX;
    end else begin
      mag = neg_x[MAG_W-1:0];
    end
  end

  assign is_wr  = (item.command == CMD_WRITE);
  assign idx_ok = ({{(32-IDX_W){1'b0}}, item.entry_index} <= 32'(SEG_COUNT));

  // drop writes beyond the table; they are accepted but never queued
  assign item.ready = q_ready;
  assign q_valid    = item.valid && (!is_wr || idx_ok);

  assign q_ctl.wr   = is_wr;
  assign q_ctl.neg  = item.sample[SAMPLE_W-1];
  assign q_ctl.tail = ({{(32-MAG_W){1'b0}}, mag} >= ONE);
  assign q_ctl.blk  = item.block_end;
  assign q_val      = is_wr ? item.entry_value : {1'b0, mag};
  assign q_idx      = item.entry_index;

endmodule

// ===== sv/twsi_fifo.sv =====
// Short word queue between front end and back end.
// Depends on twsi_pkg for its default depth.
module twsi_fifo import twsi_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [0:DEPTH-1];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

endmodule

// ===== sv/twsi_back.sv =====
// Back end: curve memory, interpolation / tail-line datapath and output register.
// Depends on twsi_pkg and twsi_out_if.
module twsi_back import twsi_pkg::*; #(
  parameter int SEG_COUNT  = SEG_COUNT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int IDX_W      = $clog2(SEG_COUNT_DEF + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  twsi_ctl_t                  ctl,
  input  logic [SAMPLE_W-1:0]        val,
  input  logic [IDX_W-1:0]           idx,
  input  logic signed [SAMPLE_W-1:0] slope,
  input  logic signed [SAMPLE_W-1:0] offset,
  twsi_out_if.source                 result
);

  localparam int WT_W = FRAC_BITS + 1;
  localparam int SC_W = MAG_W + IDX_W + FRAC_BITS;
  localparam int PR_W = SAMPLE_W + WT_W + 1;
  localparam int TP_W = 2 * SAMPLE_W;
  localparam int WW   = 2 * SAMPLE_W + FRAC_BITS + 2;
  localparam int LIM  = 2 << FRAC_BITS;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic [SAMPLE_W-1:0] curve_mem [0:SEG_COUNT];

  // stage 0: address generation off the queue head
  logic                       adv;
  logic                       pop;
  logic [MAG_W-1:0]           mag;
  logic [SC_W-1:0]            scaled;
  logic [IDX_W-1:0]           ra0;
  logic [IDX_W-1:0]           ra1;
  logic [MAG_W-1:0]           diff;
  logic signed [SAMPLE_W-1:0] rd0;
  logic signed [SAMPLE_W-1:0] rd1;

  assign adv       = !result.valid || result.ready;
  assign pop_ready = adv;
  assign pop       = pop_valid && adv;
  assign mag       = val[MAG_W-1:0];
  assign scaled    = SC_W'(mag) * SC_W'(SEG_COUNT);
  assign ra0       = ctl.tail ? '0 : IDX_W'(scaled >> FRAC_BITS);
  assign ra1       = ra0 + 1'b1;
  assign diff      = MAG_W'({{(32-MAG_W){1'b0}}, mag} - ONE);

  always_ff @(posedge clk) begin
    if (pop && ctl.wr) begin
      curve_mem[idx] <= val;
    end
    if (adv) begin
      rd0 <= curve_mem[ra0];
      rd1 <= curve_mem[ra1];
    end
  end

  // stage 1: table words and weights
  logic                       v1;
  logic [FRAC_BITS-1:0]       frac1;
  logic [MAG_W-1:0]           diff1;
  logic                       neg1;
  logic                       tail1;
  logic                       blk1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pop && !ctl.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frac1 <= scaled[FRAC_BITS-1:0];
      diff1 <= diff;
      neg1  <= ctl.neg;
      tail1 <= ctl.tail;
      blk1  <= ctl.blk;
    end
  end

  logic [WT_W-1:0]            w0;
  logic [WT_W-1:0]            w1;
  logic signed [SAMPLE_W-1:0] slope_c;

  assign w0 = WT_W'(ONE) - {1'b0, frac1};
  assign w1 = {1'b0, frac1};

  always_comb begin
    if (slope > LIM) begin
      slope_c = SAMPLE_W'(LIM);
    end else if (slope < -LIM) begin
      slope_c = SAMPLE_W'(-LIM);
    end else begin
      slope_c = slope;
    end
  end

  // stage 2: products
  logic                   v2;
  logic signed [PR_W-1:0] p0;
  logic signed [PR_W-1:0] p1;
  logic signed [TP_W-1:0] pt;
  logic                   neg2;
  logic                   tail2;
  logic                   blk2;
  logic                   blk2_src;

  assign blk2_src = blk1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0    <= rd0 * $signed({1'b0, w0});
      p1    <= rd1 * $signed({1'b0, w1});
      pt    <= slope_c * $signed({1'b0, diff1});
      neg2  <= neg1;
      tail2 <= tail1;
      blk2  <= blk2_src;
    end
  end

  // stage 3: sum, floor shift, sign restore, saturate
  logic signed [WW-1:0]    sum;
  logic signed [WW-1:0]    yq;
  logic signed [WW-1:0]    ys;
  logic signed [OUT_W-1:0] shaped_next;

  always_comb begin
    if (tail2) begin
      sum = WW'(pt) + (WW'(offset) <<< FRAC_BITS);
    end else begin
      sum = WW'(p0) + WW'(p1);
    end
    yq = sum >>> FRAC_BITS;
    ys = neg2 ? -yq : yq;
    if (ys > WW'(OUT_MAX)) begin
      shaped_next = OUT_W'(OUT_MAX);
    end else if (ys < WW'(OUT_MIN)) begin
      shaped_next = OUT_W'(OUT_MIN);
    end else begin
      shaped_next = ys[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.shaped        <= shaped_next;
      result.block_end_out <= blk2;
    end
  end

endmodule

// ===== sv/table_waveshaper_interp_unit.sv =====
// Odd-symmetric lookup-table waveshaper with linear interpolation. One input word is
// taken per clock when the four-word queue has room; writes load the 513-entry curve
// memory and give no result, samples give one shaped word each. An accepted sample
// passes the queue pop with memory read, the multiply, and the sum/saturate into the
// output register; the datapath sustains one word per cycle while the output is not
// stalled. The curve memory has a single write port plus two read ports.
// The curve must be fully written before samples are sent; an entry never written
// reads as an unknown value. slope and offset sit at byte addresses 0 and 4 of the
// APB port; the user must change them only while the block is idle, which it does
// not enforce. Depends on twsi_pkg, the channel interfaces, front, queue, back.
module table_waveshaper_interp_unit import twsi_pkg::*; #(
  parameter int SEG_COUNT  = SEG_COUNT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  twsi_in_if.sink               item,
  twsi_out_if.source            result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = $clog2(SEG_COUNT + 1);
  localparam int QW    = $bits(twsi_ctl_t) + SAMPLE_W + IDX_W;

  logic signed [SAMPLE_W-1:0] slope;
  logic signed [SAMPLE_W-1:0] offset;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope  <= '0;
      offset <= '0;
    end else if (cfg_wr) begin
      if (paddr[CFG_ADDR_W-1] == REG_SLOPE) begin
        slope <= pwdata[SAMPLE_W-1:0];
      end else begin
        offset <= pwdata[SAMPLE_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[CFG_ADDR_W-1])
      REG_SLOPE:  prdata = {{(CFG_DATA_W-SAMPLE_W){slope[SAMPLE_W-1]}}, slope};
      REG_OFFSET: prdata = {{(CFG_DATA_W-SAMPLE_W){offset[SAMPLE_W-1]}}, offset};
      default:    prdata = '0;
    endcase
  end

  logic                f_valid;
  logic                f_ready;
  twsi_ctl_t           f_ctl;
  logic [SAMPLE_W-1:0] f_val;
  logic [IDX_W-1:0]    f_idx;

  logic                b_valid;
  logic                b_ready;
  twsi_ctl_t           b_ctl;
  logic [SAMPLE_W-1:0] b_val;
  logic [IDX_W-1:0]    b_idx;

  twsi_front #(
    .SEG_COUNT  (SEG_COUNT),
    .FRAC_BITS  (FRAC_BITS),
    .IDX_W      (IDX_W)
  ) u_front (
    .item    (item),
    .q_ready (f_ready),
    .q_valid (f_valid),
    .q_ctl   (f_ctl),
    .q_val   (f_val),
    .q_idx   (f_idx)
  );

  twsi_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctl, f_val, f_idx}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   ({b_ctl, b_val, b_idx})
  );

  twsi_back #(
    .SEG_COUNT  (SEG_COUNT),
    .FRAC_BITS  (FRAC_BITS),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .ctl       (b_ctl),
    .val       (b_val),
    .idx       (b_idx),
    .slope     (slope),
    .offset    (offset),
    .result    (result)
  );

endmodule

// ===== sv/twsi_checker.sv =====
// Port-level checks for the table waveshaper, bound to the top level.
// Depends on twsi_pkg and table_waveshaper_interp_unit.
module twsi_checker import twsi_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             item_command,
  input logic             result_valid,
  input logic             result_ready,
  input logic [OUT_W-1:0] result_shaped,
  input logic             result_block_end_out
);

  localparam int CAP   = QUEUE_DEPTH + BACK_STAGES;
  localparam int CNT_W = $clog2(CAP + 2);

  logic [CNT_W-1:0] pending;
  logic             s_in;
  logic             s_out;

  assign s_in  = item_valid && item_ready && (item_command == CMD_SHAPE);
  assign s_out = result_valid && result_ready;

  // samples accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(s_in) - CNT_W'(s_out);
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_shaped) && $stable(result_block_end_out))
    else $error("stalled result word changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != '0)
    else $error("result word without an outstanding sample");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(CAP))
    else $error("more samples in flight than the block can hold");

endmodule

bind table_waveshaper_interp_unit twsi_checker u_twsi_checker (
  .clk                  (clk),
  .rst                  (rst),
  .item_valid           (item.valid),
  .item_ready           (item.ready),
  .item_command         (item.command),
  .result_valid         (result.valid),
  .result_ready         (result.ready),
  .result_shaped        (result.shaped),
  .result_block_end_out (result.block_end_out)
);

// ===== tb/twsi_shape_checker.sv =====
`timescale 1ns / 100ps
// Checker for the table waveshaper: mirrors the curve memory and the tail registers,
// predicts each shaped word and compares it with the result channel.
// Depends on twsi_pkg and the two channel interfaces.
module twsi_shape_checker import twsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  twsi_in_if                    item,
  twsi_out_if                   result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    pending
);

  localparam longint UNITY     = longint'(1) << FRAC_BITS_DEF;
  localparam longint SLOPE_LIM = 2 * UNITY;

  typedef struct {
    logic signed [OUT_W-1:0] shaped;
    logic                    blk;
  } shaped_word_t;

  logic signed [SAMPLE_W-1:0] curve_mem [0:SEG_COUNT_DEF];
  logic signed [SAMPLE_W-1:0] tail_slope;
  logic signed [SAMPLE_W-1:0] tail_offset;
  shaped_word_t               shaped_q [$];
  shaped_word_t               head;
  int                         fail_count;

  initial begin
    foreach (curve_mem[i]) curve_mem[i] = '0;
    tail_slope  = '0;
    tail_offset = '0;
    fail_count  = 0;
  end

  function automatic logic signed [OUT_W-1:0] shape_sample(logic signed [SAMPLE_W-1:0] x);
    longint mag, scaled, tap, frac, acc, a;
    mag = (x < 0) ? -longint'(x) : longint'(x);
    if (mag > longint'(MAG_MAX)) mag = longint'(MAG_MAX);
    if (mag < UNITY) begin
      // upper bits pick the segment, lower bits weight its two ends
      scaled = mag * SEG_COUNT_DEF;
      tap    = scaled >>> FRAC_BITS_DEF;
      frac   = scaled & (UNITY - 1);
      if (tap >= SEG_COUNT_DEF) tap = SEG_COUNT_DEF - 1;
      acc = longint'(curve_mem[tap]) * (UNITY - frac) + longint'(curve_mem[tap + 1]) * frac;
    end else begin
      a = longint'(tail_slope);
      if (a > SLOPE_LIM) a = SLOPE_LIM;
      if (a < -SLOPE_LIM) a = -SLOPE_LIM;
      acc = a * (mag - UNITY) + longint'(tail_offset) * UNITY;
    end
    acc = acc >>> FRAC_BITS_DEF;
    if (x < 0) acc = -acc;
    if (acc > OUT_MAX) acc = OUT_MAX;
    if (acc < OUT_MIN) acc = OUT_MIN;
    return OUT_W'(acc);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shaped_q.delete();
      tail_slope  = '0;
      tail_offset = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SLOPE) begin
          tail_slope = pwdata[SAMPLE_W-1:0];
        end else begin
          tail_offset = pwdata[SAMPLE_W-1:0];
        end
      end
      // retire before queueing so a stray word is never matched to a fresh sample
      if (result.valid && result.ready) begin
        if (shaped_q.size() == 0) begin
          $error("shaped word %0d with no sample pending", result.shaped);
          fail_count++;
        end else begin
          head = shaped_q.pop_front();
          if (result.shaped !== head.shaped) begin
            $error("shaped: expected %0d, got %0d", head.shaped, result.shaped);
            fail_count++;
          end
          if (result.block_end_out !== head.blk) begin
            $error("block_end_out: expected %0b, got %0b", head.blk, result.block_end_out);
            fail_count++;
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.command == CMD_WRITE) begin
          // drop writes past the last entry
          if (item.entry_index <= SEG_COUNT_DEF) curve_mem[item.entry_index] = item.entry_value;
        end else begin
          shaped_q.push_back('{shape_sample(item.sample), item.block_end});
        end
      end
    end
    mismatches <= fail_count;
    pending    <= shaped_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the table waveshaper testbench: reset, curve loading, tail settings and random
// sample traffic with idling on both channels; the verdict comes from the checker.
// Depends on twsi_pkg, the channel interfaces, the block and twsi_shape_checker.
module tb;
  import twsi_pkg::*;

  localparam int IDX_W        = $clog2(SEG_COUNT_DEF + 1);
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_WORDS  = 4;
  localparam int PHASES       = 7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    pending;
  bit                    steady_tx;

  twsi_in_if  item_ch ();
  twsi_out_if result_ch ();

  table_waveshaper_interp_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  twsi_shape_checker i_chk (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r, mag;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      mag = $urandom_range(0, 32767);
      return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    end
    if (r < 8) return SAMPLE_W'($urandom);
    if (r == 8) begin
      // land on or just short of a table point
      mag = ($urandom_range(0, SEG_COUNT_DEF - 1) << 6) + ($urandom_range(0, 1) ? 63 : 0);
      return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    end
    case ($urandom_range(0, 7))
      0:       return SAMPLE_W'(32767);
      1:       return SAMPLE_W'(32768);
      2:       return SAMPLE_W'(-32768);
      3:       return SAMPLE_W'(-32767);
      4:       return SAMPLE_W'(131071);
      5:       return SAMPLE_W'(-131072);
      6:       return SAMPLE_W'(-131071);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_entry();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_W'(131071);
      1:       return SAMPLE_W'(-131072);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(logic cmd, logic signed [SAMPLE_W-1:0] smp, logic [IDX_W-1:0] idx,
                           logic signed [SAMPLE_W-1:0] val, logic blk);
    int gap;
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.command     <= cmd;
    item_ch.sample      <= smp;
    item_ch.entry_index <= idx;
    item_ch.entry_value <= val;
    item_ch.block_end   <= blk;
    item_ch.valid       <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic shape(logic signed [SAMPLE_W-1:0] smp, logic blk);
    send_word(CMD_SHAPE, smp, IDX_W'($urandom), SAMPLE_W'($urandom), blk);
  endtask

  task automatic load_entry(int idx, logic signed [SAMPLE_W-1:0] val);
    send_word(CMD_WRITE, SAMPLE_W'($urandom), IDX_W'(idx), val, 1'($urandom));
  endtask

  // leaves psel high so a following write goes straight into its setup cycle
  task automatic apb_write(logic reg_sel, logic signed [SAMPLE_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({reg_sel, 2'b00});
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_tail(logic signed [SAMPLE_W-1:0] slope_val,
                          logic signed [SAMPLE_W-1:0] offset_val);
    apb_write(REG_SLOPE, slope_val);
    apb_write(REG_OFFSET, offset_val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid, wait for every shaped word, then let trailing writes clear the pipe
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_words(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) steady_tx = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        shape(pick_sample(), 1'($urandom_range(0, 7) == 0));
      end else if (r < 96) begin
        load_entry($urandom_range(0, SEG_COUNT_DEF), pick_entry());
      end else begin
        load_entry($urandom_range(SEG_COUNT_DEF + 1, (1 << IDX_W) - 1), pick_entry());
      end
    end
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      int run, stall;
      run = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 8);
      result_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] slope_set  [PHASES];
    logic signed [SAMPLE_W-1:0] offset_set [PHASES];
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.command     <= CMD_WRITE;
    item_ch.sample      <= '0;
    item_ch.entry_index <= '0;
    item_ch.entry_value <= '0;
    item_ch.block_end   <= 1'b0;
    steady_tx = 1'b0;
    slope_set  = '{0, 65536, -65536, 131071, -131072, 0, 0};
    offset_set = '{0, 131071, -131072, -131072, 131071, 0, 0};
    slope_set[5]  = SAMPLE_W'($urandom);
    offset_set[5] = SAMPLE_W'($urandom);
    slope_set[6]  = SAMPLE_W'($urandom);
    offset_set[6] = SAMPLE_W'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_tail(32768, 16384);

    // fill the whole curve before any sample goes in
    for (int i = 0; i <= SEG_COUNT_DEF; i++) load_entry(i, pick_entry());

    load_entry(0, -131072);
    load_entry(1, 131071);
    load_entry(SEG_COUNT_DEF - 1, -131072);
    load_entry(SEG_COUNT_DEF, 131071);
    load_entry(SEG_COUNT_DEF + 1, 12345);
    load_entry((1 << IDX_W) - 1, -1);
    shape(0, 1'b0);
    shape(1, 1'b1);
    shape(-1, 1'b0);
    shape(63, 1'b0);
    shape(64, 1'b1);
    shape(-64, 1'b0);
    shape(32704, 1'b0);
    shape(32767, 1'b1);
    shape(-32767, 1'b0);
    shape(32768, 1'b0);
    shape(-32768, 1'b1);
    shape(65536, 1'b0);
    shape(-98304, 1'b0);
    shape(131071, 1'b1);
    shape(-131071, 1'b0);
    shape(-131072, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_tail(slope_set[p], offset_set[p]);
      random_words(PHASE_WORDS);
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
